// ===== rtl/keyed_baseline_angle_tracker_macros.svh =====
// Assertion macros shared by the angle tracker modules.
// No dependencies; the modules that use these macros include this file.
`ifndef KEYED_BASELINE_ANGLE_TRACKER_MACROS_SVH
`define KEYED_BASELINE_ANGLE_TRACKER_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define KBAT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define KBAT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/kbat_pkg.sv =====
// Package for the keyed baseline angle tracker: widths, types, register codes.
// No dependencies; used by every module of the block.
package kbat_pkg;

  localparam int SlotsDef = 8;
  localparam int KeyW     = 48;
  localparam int AngW     = 17;
  localparam int CfgW     = 16;
  localparam int AddrW    = 4;
  localparam int DataW    = 32;

  localparam logic [CfgW-1:0] LowerRst  = 16'd128;
  localparam logic [CfgW-1:0] UpperRst  = 16'd18048;
  localparam logic [CfgW-1:0] WindowRst = 16'd960;

  typedef logic [KeyW-1:0]        key_t;
  typedef logic signed [AngW-1:0] angle_t;
  typedef logic [CfgW-1:0]        cfg_word_t;

  typedef enum logic [1:0] {
    RegLower  = 2'd0,
    RegUpper  = 2'd1,
    RegWindow = 2'd2
  } reg_idx_e;

  typedef struct packed {
    cfg_word_t lower;
    cfg_word_t upper;
    cfg_word_t window;
  } cfg_t;

  typedef struct packed {
    angle_t base;
    logic   widen;
  } tbl_res_t;

  function automatic logic in_bounds(angle_t a, cfg_t cfg);
    return (a > $signed({1'b0, cfg.lower})) && (a < $signed({1'b0, cfg.upper}));
  endfunction

endpackage

// ===== rtl/kbat_cfg.sv =====
// Configuration registers of the angle tracker behind an APB-style port.
// Depends on kbat_pkg for the register codes and the configuration struct.
module kbat_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kbat_pkg::AddrW-1:0]    paddr,
  input  logic [kbat_pkg::DataW-1:0]    pwdata,
  output logic [kbat_pkg::DataW-1:0]    prdata,
  output logic                          pready,
  output kbat_pkg::cfg_t                cfg_o
);
  import kbat_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        RegLower:  cfg_d.lower  = pwdata[CfgW-1:0];
        RegUpper:  cfg_d.upper  = pwdata[CfgW-1:0];
        RegWindow: cfg_d.window = pwdata[CfgW-1:0];
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegLower:  prdata = {{(DataW-CfgW){1'b0}}, cfg_q.lower};
      RegUpper:  prdata = {{(DataW-CfgW){1'b0}}, cfg_q.upper};
      RegWindow: prdata = {{(DataW-CfgW){1'b0}}, cfg_q.window};
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lower  <= LowerRst;
      cfg_q.upper  <= UpperRst;
      cfg_q.window <= WindowRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== rtl/kbat_table.sv =====
// Slot table of the angle tracker: parallel key match, base update and insertion.
// Depends on kbat_pkg and on the assertion macros header.
`include "keyed_baseline_angle_tracker_macros.svh"
module kbat_table #(
  parameter int SLOTS = kbat_pkg::SlotsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 track_i,
  input  logic                 clear_i,
  input  kbat_pkg::key_t       key_i,
  input  kbat_pkg::angle_t     angle_i,
  input  kbat_pkg::cfg_word_t  window_i,
  output kbat_pkg::tbl_res_t   res_o
);
  import kbat_pkg::*;

  localparam int PtrW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  key_t              key_q  [SLOTS];
  angle_t            base_q [SLOTS];
  logic [SLOTS-1:0]  valid_q;
  logic [PtrW-1:0]   ptr_q, ptr_d, ptr_inc;
  logic [SLOTS-1:0]  hit_vec;
  logic              hit;
  angle_t            hit_base;
  logic signed [AngW:0] rise;
  logic              rise_wide;
  logic              rise_neg;
  logic              replace;

  always_comb begin
    hit_base = '0;
    for (int i = 0; i < SLOTS; i++) begin
      hit_vec[i] = valid_q[i] && (key_q[i] == key_i);
      if (hit_vec[i]) begin
        hit_base = hit_base | base_q[i];
      end
    end
  end

  assign hit       = |hit_vec;
  assign rise      = {angle_i[AngW-1], angle_i} - {hit_base[AngW-1], hit_base};
  assign rise_wide = rise > $signed({2'b00, window_i});
  assign rise_neg  = rise[AngW];
  assign replace   = rise_wide || rise_neg;
  assign ptr_inc   = (ptr_q == PtrW'(SLOTS - 1)) ? '0 : ptr_q + 1'b1;

  always_comb begin
    res_o.base  = angle_i;
    res_o.widen = 1'b0;
    if (hit) begin
      res_o.base  = replace ? angle_i : hit_base;
      res_o.widen = rise_wide;
    end
  end

  always_comb begin
    ptr_d = ptr_q;
    if (clear_i) begin
      ptr_d = '0;
    end else if (track_i && !hit) begin
      ptr_d = ptr_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      ptr_q   <= '0;
    end else begin
      ptr_q <= ptr_d;
      for (int i = 0; i < SLOTS; i++) begin
        if (clear_i) begin
          valid_q[i] <= 1'b0;
        end else if (track_i && !hit && (ptr_q == PtrW'(i))) begin
          valid_q[i] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < SLOTS; i++) begin
      if (track_i && hit_vec[i] && replace) begin
        base_q[i] <= angle_i;
      end else if (track_i && !hit && (ptr_q == PtrW'(i))) begin
        base_q[i] <= angle_i;
        key_q[i]  <= key_i;
      end
    end
  end

  `KBAT_ASSERT_IMP(a_single_match, track_i, $onehot0(hit_vec), "more than one slot matched")
  `KBAT_ASSERT_NXT(a_clear_empties, clear_i, valid_q == '0, "slots still valid after clear")
  `KBAT_ASSERT_NXT(a_insert_advances, track_i && !clear_i && !hit, ptr_q == $past(ptr_inc),
                   "insertion pointer did not advance")

endmodule

// ===== rtl/keyed_baseline_angle_tracker.sv =====
// Keyed baseline angle tracker: one item may be started in every cycle, busy stays low.
// An item is registered at start, looked up and resolved in the
// next cycle, and its result is registered and shown with done_o for one cycle.
// Throughput is one item per cycle, set by the combinational slot match and the registered update.
// Reset empties the slot table, clears the widened flag and loads the default bounds.
// The receiver cannot stall; each result is valid for exactly one cycle.
`include "keyed_baseline_angle_tracker_macros.svh"
module keyed_baseline_angle_tracker #(
  parameter int SLOTS = kbat_pkg::SlotsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic                       func_i,
  input  kbat_pkg::key_t             camera_key_i,
  input  kbat_pkg::angle_t           horizontal_angle_i,
  input  kbat_pkg::angle_t           vertical_angle_i,
  output logic                       done_o,
  output logic                       usable_o,
  output kbat_pkg::angle_t           base_angle_o,
  output logic                       widened_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [kbat_pkg::AddrW-1:0] paddr,
  input  logic [kbat_pkg::DataW-1:0] pwdata,
  output logic [kbat_pkg::DataW-1:0] prdata,
  output logic                       pready
);
  import kbat_pkg::*;

  cfg_t     cfg;
  tbl_res_t tbl_res;

  logic   in_vld_q;
  logic   func_q;
  key_t   key_q;
  angle_t h_q, v_q;

  logic   usable;
  logic   track;
  logic   clear;

  logic   wid_q, wid_d;
  logic   done_q;
  logic   usable_q, usable_d;
  angle_t base_q, base_d;

  assign busy = 1'b0;

  kbat_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign usable = in_bounds(h_q, cfg) && in_bounds(v_q, cfg);
  assign track  = in_vld_q && !func_q && usable;
  assign clear  = in_vld_q && func_q;

  kbat_table #(
    .SLOTS (SLOTS)
  ) u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .track_i  (track),
    .clear_i  (clear),
    .key_i    (key_q),
    .angle_i  (h_q),
    .window_i (cfg.window),
    .res_o    (tbl_res)
  );

  always_comb begin
    wid_d    = wid_q;
    usable_d = 1'b0;
    base_d   = '0;
    if (track) begin
      wid_d    = tbl_res.widen;
      usable_d = 1'b1;
      base_d   = tbl_res.base;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      done_q   <= 1'b0;
      wid_q    <= 1'b0;
    end else begin
      in_vld_q <= start && !busy;
      done_q   <= in_vld_q;
      wid_q    <= wid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      func_q <= func_i;
      key_q  <= camera_key_i;
      h_q    <= horizontal_angle_i;
      v_q    <= vertical_angle_i;
    end
    usable_q <= usable_d;
    base_q   <= base_d;
  end

  assign done_o       = done_q;
  assign usable_o     = usable_q;
  assign base_angle_o = base_q;
  assign widened_o    = wid_q;

  `KBAT_ASSERT_NXT(a_start_registers, start && !busy, in_vld_q, "started item not registered")
  `KBAT_ASSERT_NXT(a_item_gives_result, in_vld_q, done_o, "registered item gave no result")
  `KBAT_ASSERT_IMP(a_unusable_base_zero, done_o && !usable_o, base_angle_o == '0,
                   "unusable item reports a non-zero base")

endmodule

// ===== sim/keyed_baseline_angle_tracker_tb.sv =====
// Self-checking testbench for the keyed baseline angle tracker: a directed table, then random
// readings under several bound settings, each result checked against its typed expectation or an in-bench tracker.
// Depends on kbat_pkg and keyed_baseline_angle_tracker only.
module keyed_baseline_angle_tracker_tb;
  import kbat_pkg::*;

  localparam int Slots = SlotsDef;
  localparam logic [1:0] RegUnused = 2'd3;
  localparam int MaxShown = 10;
  localparam int PoolSize = 12;

  typedef enum logic {
    FuncRead  = 1'b0,
    FuncClear = 1'b1
  } func_e;

  typedef struct packed {
    logic   usable;
    angle_t base;
    logic   widen;
  } reading_res_t;

  typedef struct {
    func_e  func;
    key_t   key;
    angle_t hor;
    angle_t ver;
    logic   typed;
    logic   usable;
    angle_t base;
    logic   widen;
  } reading_row_t;

  logic                clk_i              = 1'b0;
  logic                rst_ni             = 1'b0;
  logic                start              = 1'b0;
  logic                busy;
  logic                func_i             = 1'b0;
  key_t                camera_key_i       = '0;
  angle_t              horizontal_angle_i = '0;
  angle_t              vertical_angle_i   = '0;
  logic                done_o;
  logic                usable_o;
  angle_t              base_angle_o;
  logic                widened_o;
  logic                psel               = 1'b0;
  logic                penable            = 1'b0;
  logic                pwrite             = 1'b0;
  logic [AddrW-1:0]    paddr              = '0;
  logic [DataW-1:0]    pwdata             = '0;
  logic [DataW-1:0]    prdata;
  logic                pready;

  // A typed expectation travels with its item and replaces the tracker's answer.
  logic                row_typed          = 1'b0;
  reading_res_t        row_res            = '0;

  cfg_word_t           lower_q            = LowerRst;
  cfg_word_t           upper_q            = UpperRst;
  cfg_word_t           window_q           = WindowRst;
  key_t                trk_key   [Slots]  = '{default: '0};
  angle_t              trk_base  [Slots]  = '{default: '0};
  logic                trk_valid [Slots]  = '{default: 1'b0};
  int unsigned         trk_ptr            = 0;
  logic                trk_widen          = 1'b0;

  reading_res_t        pending_q [$];
  int unsigned         errors             = 0;
  int unsigned         idle_pct           = 0;
  key_t                key_pool [PoolSize];

  reading_row_t directed_rows [25] = '{
    '{FuncRead,  48'h0,              17'sd1000,  17'sd1000,  1'b1, 1'b1, 17'sd1000,  1'b0},
    '{FuncRead,  48'h0,              17'sd1500,  17'sd5000,  1'b1, 1'b1, 17'sd1000,  1'b0},
    '{FuncRead,  48'h0,              17'sd1960,  17'sd18047, 1'b1, 1'b1, 17'sd1000,  1'b0},
    '{FuncRead,  48'h0,              17'sd1961,  17'sd129,   1'b1, 1'b1, 17'sd1961,  1'b1},
    '{FuncRead,  48'h0,              17'sd128,   17'sd1000,  1'b1, 1'b0, 17'sd0,     1'b1},
    '{FuncRead,  48'h0,              17'sd1000,  17'sd18048, 1'b1, 1'b0, 17'sd0,     1'b1},
    '{FuncRead,  48'hFFFF_FFFF_FFFF, 17'sd129,   17'sd18047, 1'b1, 1'b1, 17'sd129,   1'b0},
    '{FuncRead,  48'h0,              17'sd1960,  17'sd1000,  1'b1, 1'b1, 17'sd1960,  1'b0},
    '{FuncRead,  48'h0,              17'h10000,  17'h10000,  1'b1, 1'b0, 17'sd0,     1'b0},
    '{FuncRead,  48'h0,              17'h0FFFF,  17'h0FFFF,  1'b1, 1'b0, 17'sd0,     1'b0},
    '{FuncRead,  48'h0,              17'h1FFFF,  17'sd1000,  1'b1, 1'b0, 17'sd0,     1'b0},
    '{FuncRead,  48'h5555_5555_5555, 17'sd2000,  17'sd9000,  1'b1, 1'b1, 17'sd2000,  1'b0},
    '{FuncRead,  48'hAAAA_AAAA_AAAA, 17'sd3000,  17'sd9000,  1'b1, 1'b1, 17'sd3000,  1'b0},
    '{FuncRead,  48'h3,              17'sd4000,  17'sd9000,  1'b1, 1'b1, 17'sd4000,  1'b0},
    '{FuncRead,  48'h4,              17'sd5000,  17'sd9000,  1'b1, 1'b1, 17'sd5000,  1'b0},
    '{FuncRead,  48'h5,              17'sd6000,  17'sd9000,  1'b1, 1'b1, 17'sd6000,  1'b0},
    '{FuncRead,  48'h6,              17'sd7000,  17'sd9000,  1'b1, 1'b1, 17'sd7000,  1'b0},
    '{FuncRead,  48'h7,              17'sd8000,  17'sd9000,  1'b1, 1'b1, 17'sd8000,  1'b0},
    '{FuncRead,  48'h0,              17'sd9000,  17'sd9000,  1'b1, 1'b1, 17'sd9000,  1'b0},
    '{FuncRead,  48'hFFFF_FFFF_FFFF, 17'sd10000, 17'sd9000,  1'b0, 1'b0, 17'sd0,     1'b0},
    '{FuncClear, 48'h1234_5678_9ABC, 17'h1ABCD,  17'h0AAAA,  1'b1, 1'b0, 17'sd0,     1'b0},
    '{FuncRead,  48'h0,              17'sd3000,  17'sd3000,  1'b0, 1'b0, 17'sd0,     1'b0},
    '{FuncRead,  48'h0,              17'sd15000, 17'sd3000,  1'b0, 1'b0, 17'sd0,     1'b0},
    '{FuncClear, 48'hFEDC_BA98_7654, 17'h15555,  17'h00001,  1'b0, 1'b0, 17'sd0,     1'b0},
    '{FuncRead,  48'h0,              17'sd100,   17'sd3000,  1'b0, 1'b0, 17'sd0,     1'b0}
  };

  keyed_baseline_angle_tracker #(
    .SLOTS(Slots)
  ) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .func_i            (func_i),
    .camera_key_i      (camera_key_i),
    .horizontal_angle_i(horizontal_angle_i),
    .vertical_angle_i  (vertical_angle_i),
    .done_o            (done_o),
    .usable_o          (usable_o),
    .base_angle_o      (base_angle_o),
    .widened_o         (widened_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic angle_in_bounds(angle_t a);
    int ang;
    ang = a;
    return (ang > int'(lower_q)) && (ang < int'(upper_q));
  endfunction

  function automatic reading_res_t track_reading(func_e func, key_t key, angle_t hor,
                                                 angle_t ver);
    reading_res_t res;
    int           hor_val;
    int           base_val;
    logic         hit;
    res       = '0;
    res.widen = trk_widen;
    if (func == FuncClear) begin
      foreach (trk_valid[i]) trk_valid[i] = 1'b0;
      trk_ptr = 0;
      return res;
    end
    if (!(angle_in_bounds(hor) && angle_in_bounds(ver))) begin
      return res;
    end
    trk_widen = 1'b0;
    hit       = 1'b0;
    res.base  = hor;
    hor_val   = hor;
    for (int i = 0; i < Slots; i++) begin
      if (!hit && trk_valid[i] && trk_key[i] == key) begin
        hit      = 1'b1;
        base_val = trk_base[i];
        if (hor_val - base_val > int'(window_q)) begin
          trk_widen   = 1'b1;
          trk_base[i] = hor;
        end else if (hor_val - base_val < 0) begin
          trk_base[i] = hor;
        end
        res.base = trk_base[i];
      end
    end
    if (!hit) begin
      trk_key[trk_ptr]   = key;
      trk_base[trk_ptr]  = hor;
      trk_valid[trk_ptr] = 1'b1;
      trk_ptr            = (trk_ptr + 1) % Slots;
    end
    res.usable = 1'b1;
    res.widen  = trk_widen;
    return res;
  endfunction

  function automatic void flag_error(string msg);
    errors++;
    if (errors <= MaxShown) begin
      $display("%s", msg);
    end
  endfunction

  always @(posedge clk_i) begin
    reading_res_t want;
    reading_res_t got;
    if (rst_ni) begin
      got = '{usable: usable_o, base: base_angle_o, widen: widened_o};
      if (done_o) begin
        if (pending_q.size() == 0) begin
          flag_error($sformatf("result with no item outstanding: usable=%0b base=%0d widened=%0b",
                               got.usable, got.base, got.widen));
        end else begin
          want = pending_q.pop_front();
          if (got.usable !== want.usable || got.base !== want.base || got.widen !== want.widen)
          begin
            flag_error($sformatf(
              "mismatch: expected usable=%0b base=%0d widened=%0b, got usable=%0b base=%0d widened=%0b",
              want.usable, want.base, want.widen, got.usable, got.base, got.widen));
          end
        end
      end
      if (start && !busy) begin
        want = track_reading(func_e'(func_i), camera_key_i, horizontal_angle_i,
                             vertical_angle_i);
        pending_q.push_back(row_typed ? row_res : want);
      end
    end
  end

  task automatic send_reading(func_e func, key_t key, angle_t hor, angle_t ver, logic typed,
                              reading_res_t res);
    logic taken;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start              <= 1'b1;
    func_i             <= func;
    camera_key_i       <= key;
    horizontal_angle_i <= hor;
    vertical_angle_i   <= ver;
    row_typed          <= typed;
    row_res            <= res;
    do begin
      @(negedge clk_i);
      taken = !busy;
      @(posedge clk_i);
    end while (!taken);
  endtask

  task automatic wait_drained(int unsigned tail);
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, cfg_word_t value);
    logic ready;
    wait_drained(4);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
      ready = pready;
      @(posedge clk_i);
    end while (!ready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegLower:  lower_q  = value;
      RegUpper:  upper_q  = value;
      RegWindow: window_q = value;
      default: ;
    endcase
  endtask

  task automatic set_bounds(cfg_word_t lower, cfg_word_t upper, cfg_word_t window);
    write_reg(RegLower, lower);
    write_reg(RegUpper, upper);
    write_reg(RegWindow, window);
  endtask

  function automatic angle_t pick_angle();
    int lo;
    int hi;
    lo = int'(lower_q) + 1;
    hi = int'(upper_q) - 1;
    if (lo > hi || $urandom_range(9) == 0) begin
      return angle_t'($urandom);
    end
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(3))
        0: return angle_t'(lo - 1);
        1: return angle_t'(lo);
        2: return angle_t'(hi);
        default: return angle_t'(hi + 1);
      endcase
    end
    return angle_t'($urandom_range(hi, lo));
  endfunction

  task automatic send_random();
    func_e func;
    key_t  key;
    func = ($urandom_range(99) < 3) ? FuncClear : FuncRead;
    if ($urandom_range(9) == 0) begin
      key = {16'($urandom), 32'($urandom)};
    end else begin
      key = key_pool[$urandom_range(PoolSize - 1)];
    end
    send_reading(func, key, pick_angle(), pick_angle(), 1'b0, '0);
  endtask

  initial begin
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int unsigned sent;
    int unsigned count;
    foreach (key_pool[i]) key_pool[i] = {16'($urandom), 32'($urandom)};
    sent = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_pct = 30;
    foreach (directed_rows[i]) begin
      send_reading(directed_rows[i].func, directed_rows[i].key, directed_rows[i].hor,
                   directed_rows[i].ver, directed_rows[i].typed,
                   '{usable: directed_rows[i].usable, base: directed_rows[i].base,
                     widen: directed_rows[i].widen});
    end

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: set_bounds(LowerRst, UpperRst, WindowRst);
        1: set_bounds(16'd0, 16'hFFFF, 16'd0);
        2: begin
          write_reg(RegUnused, 16'($urandom));
          set_bounds(16'd0, 16'hFFFF, 16'hFFFF);
        end
        3: set_bounds(16'hFFFF, 16'd0, 16'd500);
        4: set_bounds(16'd5000, 16'd5000, WindowRst);
        default: set_bounds(16'($urandom_range(4000)), 16'($urandom_range(65535, 8000)),
                            16'($urandom_range(4000)));
      endcase
      count = (phase == 3 || phase == 4) ? 40 : 145;
      repeat (count) begin
        idle_pct = (sent < 317) ? 30 : (sent < 634) ? 57 : 0;
        send_random();
        sent++;
      end
    end

    wait_drained(8);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
